// ----- rtl/hdg_pkg.sv -----
// Shared types and constants for the HSV-to-GRB pixel color path.
`default_nettype none
package hdg_pkg;

    localparam logic [9:0]  HUE_WRAP   = 10'd360;
    localparam logic [9:0]  SECTOR_DEG = 10'd60;
    // 65536/60 rounded up; exact for reduced hues below 664
    localparam logic [10:0] SEC_RECIP  = 11'd1093;
    // 255/60 == 17/4
    localparam logic [9:0]  REM_MUL    = 10'd17;
    localparam logic [7:0]  CH_MAX     = 8'd255;
    localparam logic [3:0]  SEC_LAST   = 4'd11;

    localparam logic [3:0]  SEC_RED_YEL = 4'd0;
    localparam logic [3:0]  SEC_YEL_GRN = 4'd1;
    localparam logic [3:0]  SEC_GRN_CYN = 4'd2;
    localparam logic [3:0]  SEC_CYN_BLU = 4'd3;
    localparam logic [3:0]  SEC_BLU_MAG = 4'd4;

    typedef struct packed {
        logic [23:0] rgb;
        logic [7:0]  bright;
    } t_pix;

endpackage
`default_nettype wire

// ----- rtl/hdg_hsv.sv -----
// Five-stage HSV-to-RGB converter with direct-color bypass.
`default_nettype none
module hdg_hsv
    import hdg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_op,
    input  wire logic [9:0]  i_hue,
    input  wire logic [7:0]  i_saturation,
    input  wire logic [7:0]  i_level,
    input  wire logic [23:0] i_rgb_in,
    input  wire logic [7:0]  i_brightness,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_pix             o_pix
);

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    assign en5 = !r_v5 || i_ready;
    assign en4 = !r_v4 || en5;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v5;

    // stage 1: hue fold and sector
    logic [9:0]  n1_hue;
    logic [20:0] n1_prod;
    logic [3:0]  n1_sec;
    logic [9:0]  r1_hue;
    logic [3:0]  r1_sec;
    logic        r1_op;
    logic [7:0]  r1_sat, r1_lvl, r1_bright;
    logic [23:0] r1_rgb;

    assign n1_hue  = (i_hue >= HUE_WRAP) ? (i_hue - HUE_WRAP) : i_hue;
    assign n1_prod = {11'd0, n1_hue} * {10'd0, SEC_RECIP};
    assign n1_sec  = n1_prod[19:16];

    // stage 2: remainder and p
    logic [9:0]  n2_off;
    logic [9:0]  n2_rem10;
    logic [15:0] n2_pprod;
    logic [7:0]  r2_rem, r2_p;
    logic [3:0]  r2_sec;
    logic        r2_op;
    logic [7:0]  r2_sat, r2_lvl, r2_bright;
    logic [23:0] r2_rgb;

    assign n2_off   = r1_hue - ({6'd0, r1_sec} * SECTOR_DEG);
    assign n2_rem10 = {4'd0, n2_off[5:0]} * REM_MUL;
    assign n2_pprod = {8'd0, r1_lvl} * {8'd0, CH_MAX - r1_sat};

    // stage 3: saturation scaling
    logic [15:0] n3_sq, n3_st;
    logic [7:0]  r3_sq, r3_st, r3_p;
    logic [3:0]  r3_sec;
    logic        r3_op;
    logic [7:0]  r3_lvl, r3_bright;
    logic [23:0] r3_rgb;

    assign n3_sq = {8'd0, r2_sat} * {8'd0, r2_rem};
    assign n3_st = {8'd0, r2_sat} * {8'd0, CH_MAX - r2_rem};

    // stage 4: q and t
    logic [15:0] n4_q, n4_t;
    logic [7:0]  r4_q, r4_t, r4_p;
    logic [3:0]  r4_sec;
    logic        r4_op;
    logic [7:0]  r4_lvl, r4_bright;
    logic [23:0] r4_rgb;

    assign n4_q = {8'd0, r3_lvl} * {8'd0, CH_MAX - r3_sq};
    assign n4_t = {8'd0, r3_lvl} * {8'd0, CH_MAX - r3_st};

    // stage 5: channel select
    logic [23:0] n5_hsv;
    t_pix        r5_pix;

    always_comb begin
        case (r4_sec)
            SEC_RED_YEL: n5_hsv = {r4_lvl, r4_t, r4_p};
            SEC_YEL_GRN: n5_hsv = {r4_q, r4_lvl, r4_p};
            SEC_GRN_CYN: n5_hsv = {r4_p, r4_lvl, r4_t};
            SEC_CYN_BLU: n5_hsv = {r4_p, r4_q, r4_lvl};
            SEC_BLU_MAG: n5_hsv = {r4_t, r4_p, r4_lvl};
            default:     n5_hsv = {r4_lvl, r4_p, r4_q};
        endcase
    end

    assign o_pix = r5_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_hue    <= n1_hue;
            r1_sec    <= n1_sec;
            r1_op     <= i_op;
            r1_sat    <= i_saturation;
            r1_lvl    <= i_level;
            r1_rgb    <= i_rgb_in;
            r1_bright <= i_brightness;
        end
        if (en2) begin
            r2_rem    <= n2_rem10[9:2];
            r2_p      <= n2_pprod[15:8];
            r2_sec    <= r1_sec;
            r2_op     <= r1_op;
            r2_sat    <= r1_sat;
            r2_lvl    <= r1_lvl;
            r2_rgb    <= r1_rgb;
            r2_bright <= r1_bright;
        end
        if (en3) begin
            r3_sq     <= n3_sq[15:8];
            r3_st     <= n3_st[15:8];
            r3_p      <= r2_p;
            r3_sec    <= r2_sec;
            r3_op     <= r2_op;
            r3_lvl    <= r2_lvl;
            r3_rgb    <= r2_rgb;
            r3_bright <= r2_bright;
        end
        if (en4) begin
            r4_q      <= n4_q[15:8];
            r4_t      <= n4_t[15:8];
            r4_p      <= r3_p;
            r4_sec    <= r3_sec;
            r4_op     <= r3_op;
            r4_lvl    <= r3_lvl;
            r4_rgb    <= r3_rgb;
            r4_bright <= r3_bright;
        end
        if (en5) begin
            r5_pix.rgb    <= r4_op ? r4_rgb : n5_hsv;
            r5_pix.bright <= r4_bright;
        end
    end

    a_sec_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (r1_sec <= SEC_LAST))
        else $error("sector out of range");

    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v1 |-> (n2_off < SECTOR_DEG))
        else $error("sector remainder not below 60");

    a_qt_le_v: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> ((r4_q <= r4_lvl) && (r4_t <= r4_lvl)))
        else $error("q or t above value");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (r_v1 && r_v2 && r_v3 && r_v4 && r_v5 && !i_ready))
        else $error("back pressure with a bubble in the pipe");

endmodule
`default_nettype wire

// ----- rtl/hdg_dim.sv -----
// Brightness scaler and GRB repack output stage.
`default_nettype none
module hdg_dim
    import hdg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire t_pix        i_pix,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [23:0]      o_grb_word
);

    logic        en;
    logic        r_vld;
    logic [15:0] n_r, n_g, n_b;
    logic [23:0] r_grb;

    assign en      = !r_vld || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld;
    assign o_grb_word = r_grb;

    assign n_r = {8'd0, i_pix.rgb[23:16]} * {8'd0, i_pix.bright};
    assign n_g = {8'd0, i_pix.rgb[15:8]}  * {8'd0, i_pix.bright};
    assign n_b = {8'd0, i_pix.rgb[7:0]}   * {8'd0, i_pix.bright};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (en) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_grb <= {n_g[15:8], n_r[15:8], n_b[15:8]};
        end
    end

endmodule
`default_nettype wire

// ----- rtl/hsv_dim_grb_pixel.sv -----
// Top level of the HSV/direct-color to dimmed GRB pixel path.
// One pixel beat is accepted every cycle while o_ready is high; each
// result passes through five converter stages plus the dimming output
// register, with the multiplies spread across the stages. Back pressure
// from i_ready stalls the pipe without dropping or repeating beats.
`default_nettype none
module hsv_dim_grb_pixel
    import hdg_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic        i_op,
    input  wire logic [9:0]  i_hue,
    input  wire logic [7:0]  i_saturation,
    input  wire logic [7:0]  i_level,
    input  wire logic [23:0] i_rgb_in,
    input  wire logic [7:0]  i_brightness,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [23:0]      o_grb_word
);

    logic hsv_valid;
    logic dim_ready;
    t_pix hsv_pix;

    hdg_hsv u_hsv (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (i_op),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_level      (i_level),
        .i_rgb_in     (i_rgb_in),
        .i_brightness (i_brightness),
        .o_valid      (hsv_valid),
        .i_ready      (dim_ready),
        .o_pix        (hsv_pix)
    );

    hdg_dim u_dim (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (hsv_valid),
        .o_ready    (dim_ready),
        .i_pix      (hsv_pix),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_grb_word (o_grb_word)
    );

endmodule
`default_nettype wire

// ----- tb/hsv_dim_grb_pixel_test.sv -----
// Self-checking testbench for the HSV/direct-color to dimmed GRB pixel path.
module hsv_dim_grb_pixel_test;
    import hdg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic OP_HSV    = 1'b0;
    localparam logic OP_DIRECT = 1'b1;
    localparam int   RANDOM_PIXELS = 1430;

    typedef struct packed {
        logic        op;
        logic [9:0]  hue;
        logic [7:0]  sat;
        logic [7:0]  level;
        logic [23:0] rgb;
        logic [7:0]  bright;
    } pixel_beat_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [23:0] o_grb_word;
    pixel_beat_t cur_pixel = '0;

    pixel_beat_t pixel_backlog[$];
    logic [23:0] grb_expected[$];
    int unsigned src_idle_pct = 19;
    int unsigned snk_idle_pct = 19;
    int          stall_left = 0;
    bit          long_stall_req = 1'b0;
    bit          beat_taken = 1'b0;
    int          mismatch_count = 0;

    hsv_dim_grb_pixel dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_op         (cur_pixel.op),
        .i_hue        (cur_pixel.hue),
        .i_saturation (cur_pixel.sat),
        .i_level      (cur_pixel.level),
        .i_rgb_in     (cur_pixel.rgb),
        .i_brightness (cur_pixel.bright),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_grb_word   (o_grb_word)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic logic [23:0] grb_from_pixel(pixel_beat_t px);
        int unsigned h, sec, rem, s, v, p, q, t, ch_r, ch_g, ch_b, br;
        h = px.hue;
        s = px.sat;
        v = px.level;
        br = px.bright;
        if (h >= HUE_WRAP)
            h = h - HUE_WRAP;
        sec = h / SECTOR_DEG;
        rem = ((h - sec * SECTOR_DEG) * CH_MAX) / SECTOR_DEG;
        p = (v * (255 - s)) >> 8;
        q = (v * (255 - ((s * rem) >> 8))) >> 8;
        t = (v * (255 - ((s * (255 - rem)) >> 8))) >> 8;
        if (px.op == OP_DIRECT) begin
            ch_r = px.rgb[23:16];
            ch_g = px.rgb[15:8];
            ch_b = px.rgb[7:0];
        end else begin
            case (sec)
                SEC_RED_YEL: begin ch_r = v; ch_g = t; ch_b = p; end
                SEC_YEL_GRN: begin ch_r = q; ch_g = v; ch_b = p; end
                SEC_GRN_CYN: begin ch_r = p; ch_g = v; ch_b = t; end
                SEC_CYN_BLU: begin ch_r = p; ch_g = q; ch_b = v; end
                SEC_BLU_MAG: begin ch_r = t; ch_g = p; ch_b = v; end
                default:     begin ch_r = v; ch_g = p; ch_b = q; end
            endcase
        end
        ch_r = ((ch_r & 8'hFF) * br) >> 8;
        ch_g = ((ch_g & 8'hFF) * br) >> 8;
        ch_b = ((ch_b & 8'hFF) * br) >> 8;
        return {ch_g[7:0], ch_r[7:0], ch_b[7:0]};
    endfunction

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic pixel_beat_t rand_pixel();
        pixel_beat_t px;
        px.op = $urandom_range(1) ? OP_DIRECT : OP_HSV;
        if ($urandom_range(9) == 0)
            px.hue = 10'($urandom_range(1023, 720));
        else
            px.hue = 10'($urandom_range(719));
        px.sat = rand_byte();
        px.level = rand_byte();
        px.rgb = 24'($urandom);
        px.bright = rand_byte();
        return px;
    endfunction

    task automatic queue_pixel(logic op, logic [9:0] hue, logic [7:0] sat, logic [7:0] level,
                               logic [23:0] rgb, logic [7:0] bright);
        pixel_beat_t px;
        px = '{op: op, hue: hue, sat: sat, level: level, rgb: rgb, bright: bright};
        pixel_backlog.push_back(px);
    endtask

    task automatic queue_random(int count);
        repeat (count) pixel_backlog.push_back(rand_pixel());
    endtask

    task automatic wait_drained();
        while (pixel_backlog.size() != 0 || i_valid || grb_expected.size() != 0)
            @(negedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || beat_taken) begin
            if (pixel_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                cur_pixel <= pixel_backlog.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output back pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (long_stall_req) begin
            long_stall_req = 1'b0;
            stall_left = 120;
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // predict on input beat, check on output beat
    always @(posedge i_clk) begin
        logic [23:0] want;
        beat_taken = i_rst_n && i_valid && o_ready;
        if (beat_taken)
            grb_expected.push_back(grb_from_pixel(cur_pixel));
        if (i_rst_n && o_valid && i_ready) begin
            if (grb_expected.size() == 0) begin
                $error("grb_word: no beat pending, actual %h", o_grb_word);
                mismatch_count++;
            end else begin
                want = grb_expected.pop_front();
                if (o_grb_word !== want) begin
                    $error("grb_word: expected %h actual %h", want, o_grb_word);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #400000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // sector edges, hue wrap, out-of-range hues
        queue_pixel(OP_HSV, 10'd0,    8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd59,   8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd60,   8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd119,  8'd255, 8'd255, 24'hFFFFFF, 8'd255);
        queue_pixel(OP_HSV, 10'd120,  8'd200, 8'd180, 24'h000000, 8'd128);
        queue_pixel(OP_HSV, 10'd180,  8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd240,  8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd300,  8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd359,  8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd360,  8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd719,  8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd720,  8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd900,  8'd170, 8'd240, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd1023, 8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd512,  8'd0,   8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_HSV, 10'd45,   8'd255, 8'd0,   24'hFFFFFF, 8'd255);
        queue_pixel(OP_HSV, 10'd30,   8'd128, 8'd200, 24'h000000, 8'd0);
        // direct color, unused hue fields set
        queue_pixel(OP_DIRECT, 10'd0,    8'd0,   8'd0,   24'hFFFFFF, 8'd255);
        queue_pixel(OP_DIRECT, 10'd1023, 8'd255, 8'd255, 24'h000000, 8'd255);
        queue_pixel(OP_DIRECT, 10'd0,    8'd0,   8'd0,   24'hFFFFFF, 8'd0);
        queue_pixel(OP_DIRECT, 10'd1023, 8'd255, 8'd255, 24'hA5A5A5, 8'd128);
        queue_pixel(OP_DIRECT, 10'd333,  8'd77,  8'd99,  24'h123456, 8'd1);
        wait_drained();

        // full-rate stretch
        src_idle_pct = 0;
        snk_idle_pct = 0;
        queue_random(300);
        wait_drained();

        // long output stall while input keeps offering
        src_idle_pct = 19;
        snk_idle_pct = 19;
        queue_random(200);
        repeat (10) @(negedge i_clk);
        long_stall_req = 1'b1;
        wait_drained();

        queue_random(RANDOM_PIXELS - 500);
        wait_drained();
        repeat (20) @(negedge i_clk);

        if (mismatch_count == 0 && grb_expected.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/hdg_pkg.sv
rtl/hdg_hsv.sv
rtl/hdg_dim.sv
rtl/hsv_dim_grb_pixel.sv
tb/hsv_dim_grb_pixel_test.sv
